/* rtl/swts_pkg.sv */
// Shared types and constants for the sleep/wake time-slice scheduler.
package swts_pkg;

    localparam int ID_W    = 4;
    localparam int CLK_W   = 32;
    localparam int RUN_W   = 16;
    localparam int REQ_W   = 2;
    localparam int KIND_W  = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [RUN_W-1:0] SLICE_LEN_RST = 16'd10;

    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SLEEP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd2;

    localparam logic [KIND_W-1:0] EV_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] EV_WOKEN   = 2'd1;
    localparam logic [KIND_W-1:0] EV_PREEMPT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic capture;
        logic tick_start;
        logic sleep_do;
        logic dispatch_do;
        logic walk;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             walk_done;
        logic             flush_done;
    } status_t;

endpackage

/* rtl/sleep_wake_time_slice_scheduler.sv */
// Top level of the sleep/wake time-slice scheduler.
//
// Channel   Direction  Signals                                       Contents
// s_axis    in         tvalid tready tdata[39:0] tuser[1:0]           request transaction
// m_axis    out        tvalid tready tdata[7:0] tuser[1:0] tlast      event transaction
// cfg       in         cfg_we cfg_wdata[15:0]                         slice length register
//
// One transaction at a time. Sleep, dispatch and unknown requests pass through capture,
// execute and flush; a tick also walks the sleep queue between execute and flush, which
// examines one entry per cycle unless m_axis stalls, and a preempting tick adds a flush step.
// A stalled m_axis holds the walk or the flush when a further event must be sent.
// Reset clears clock, queue count, run counts and the slice register to 10.
module sleep_wake_time_slice_scheduler
    import swts_pkg::*;
#(
    parameter int NUM_PROCS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [RUN_W-1:0]       cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // proc_id[3:0], has_running[4], sleep_ticks[36:5]
    input  logic [REQ_W-1:0]       s_axis_tuser,  // req_type[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // event_id[3:0]
    output logic [KIND_W-1:0]      m_axis_tuser,  // event_kind[1:0]
    output logic                   m_axis_tlast   // last
);

    cmd_t    cmd;
    status_t status;

    swts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swts_datapath #(
        .NUM_PROCS (NUM_PROCS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser),
        .out_tlast  (m_axis_tlast),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

/* rtl/swts_ctrl.sv */
// Controller state machine: sequences capture, execution, sleep-queue walk and flush.
module swts_ctrl
    import swts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.req == REQ_TICK)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (status.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                case (status.req)
                    REQ_TICK:     cmd.tick_start  = 1'b1;
                    REQ_SLEEP:    cmd.sleep_do    = 1'b1;
                    REQ_DISPATCH: cmd.dispatch_do = 1'b1;
                    default:      cmd             = '0;
                endcase
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/swts_datapath.sv */
// Datapath: tick clock, sleep queue, wake times, run counts and the result register.
module swts_datapath
    import swts_pkg::*;
#(
    parameter int NUM_PROCS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [RUN_W-1:0]       cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  logic [REQ_W-1:0]       in_tuser,
    output logic                   out_tvalid,
    input  logic                   out_tready,
    output logic [OUT_TDATA_W-1:0] out_tdata,
    output logic [KIND_W-1:0]      out_tuser,
    output logic                   out_tlast,
    input  cmd_t                   cmd,
    output status_t                status
);

    localparam int IDX_W = $clog2(NUM_PROCS);
    localparam int CNT_W = $clog2(NUM_PROCS + 1);

    // captured transaction
    logic [REQ_W-1:0]  req_reg;
    logic [ID_W-1:0]   pid_reg;
    logic              running_reg;
    logic [CLK_W-1:0]  dur_reg;

    logic [RUN_W-1:0]  slice_len_reg;
    logic [CLK_W-1:0]  clock_reg,   clock_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  idx_reg,     idx_next;
    logic [CNT_W-1:0]  kept_reg,    kept_next;
    logic              preempt_reg, preempt_next;

    // one event held back until it is known whether it is the final one
    logic              pend_valid_reg, pend_valid_next;
    logic [KIND_W-1:0] pend_kind_reg,  pend_kind_next;
    logic [ID_W-1:0]   pend_id_reg,    pend_id_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg,  out_kind_next;
    logic [ID_W-1:0]   out_id_reg,    out_id_next;
    logic              out_last_reg,  out_last_next;

    logic [RUN_W-1:0]  run_ticks_reg [NUM_PROCS];
    logic [ID_W-1:0]   fifo_mem      [NUM_PROCS];
    logic [CLK_W-1:0]  wake_mem      [NUM_PROCS];

    logic              pid_ok;
    logic [IDX_W-1:0]  pid_idx;
    logic              can_load;
    logic              out_load;
    logic [ID_W-1:0]   walk_id;
    logic              walk_due;
    logic              walk_done;
    logic              count_free;
    logic              run_inc;
    logic [RUN_W-1:0]  run_sum;
    logic              run_we;
    logic [RUN_W-1:0]  run_wdata;
    logic              fifo_we;
    logic [IDX_W-1:0]  fifo_waddr;
    logic              wake_we;
    logic              flush_done;

    assign pid_ok     = (32'(pid_reg) < 32'(NUM_PROCS));
    assign pid_idx    = IDX_W'(pid_reg);
    assign can_load   = !out_valid_reg || out_tready;
    assign walk_id    = fifo_mem[idx_reg[IDX_W-1:0]];
    assign walk_due   = (wake_mem[IDX_W'(walk_id)] <= clock_reg);
    assign walk_done  = (idx_reg == count_reg);
    assign count_free = (count_reg < CNT_W'(NUM_PROCS));
    assign run_inc    = running_reg && (pid_reg != '0) && pid_ok;
    assign run_sum    = run_ticks_reg[pid_idx] + RUN_W'(1);

    assign status.req        = req_reg;
    assign status.walk_done  = walk_done;
    assign status.flush_done = flush_done;

    always_comb
    begin
        clock_next      = clock_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        kept_next       = kept_reg;
        preempt_next    = preempt_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        run_we          = 1'b0;
        run_wdata       = run_sum;
        fifo_we         = 1'b0;
        fifo_waddr      = kept_reg[IDX_W-1:0];
        wake_we         = 1'b0;
        flush_done      = 1'b0;

        if (cmd.tick_start)
        begin
            clock_next   = clock_reg + CLK_W'(1);
            idx_next     = '0;
            kept_next    = '0;
            preempt_next = 1'b0;
            if (run_inc)
            begin
                run_we       = 1'b1;
                preempt_next = (run_sum == slice_len_reg);
            end
        end

        if (cmd.sleep_do && running_reg && pid_ok && count_free)
        begin
            wake_we    = 1'b1;
            fifo_we    = 1'b1;
            fifo_waddr = count_reg[IDX_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.dispatch_do && pid_ok)
        begin
            run_we    = 1'b1;
            run_wdata = '0;
        end

        if (cmd.walk)
        begin
            if (walk_done)
            begin
                count_next = kept_reg;
            end
            else if (walk_due)
            begin
                // a due entry pushes the held event out, stall if one is held and the output is busy
                if (!pend_valid_reg || can_load)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load      = 1'b1;
                        out_kind_next = pend_kind_reg;
                        out_id_next   = pend_id_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_kind_next  = EV_WOKEN;
                    pend_id_next    = walk_id;
                    idx_next        = idx_reg + CNT_W'(1);
                end
            end
            else
            begin
                fifo_we   = 1'b1;
                kept_next = kept_reg + CNT_W'(1);
                idx_next  = idx_reg + CNT_W'(1);
            end
        end

        if (cmd.flush)
        begin
            if (preempt_reg)
            begin
                if (!pend_valid_reg || can_load)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load      = 1'b1;
                        out_kind_next = pend_kind_reg;
                        out_id_next   = pend_id_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_kind_next  = EV_PREEMPT;
                    pend_id_next    = pid_reg;
                    preempt_next    = 1'b0;
                end
            end
            else if (can_load)
            begin
                out_load        = 1'b1;
                out_kind_next   = pend_valid_reg ? pend_kind_reg : EV_ACK;
                out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
                flush_done      = 1'b1;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_len_reg  <= SLICE_LEN_RST;
            clock_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            kept_reg       <= '0;
            preempt_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                run_ticks_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                slice_len_reg <= cfg_wdata;
            end
            clock_reg      <= clock_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            kept_reg       <= kept_next;
            preempt_reg    <= preempt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (run_we)
            begin
                run_ticks_reg[pid_idx] <= run_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pid_reg     <= in_tdata[3:0];
            running_reg <= in_tdata[4];
            dur_reg     <= in_tdata[36:5];
            req_reg     <= in_tuser;
        end
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_id_reg   <= out_id_next;
            out_last_reg <= out_last_next;
        end
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= cmd.sleep_do ? pid_reg : walk_id;
        end
        if (wake_we)
        begin
            wake_mem[pid_idx] <= clock_reg + dur_reg;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {4'b0000, out_id_reg};
    assign out_tuser  = out_kind_reg;
    assign out_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_PROCS))
        else $error("sleep queue count beyond capacity");

    a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (kept_reg <= idx_reg))
        else $error("compaction write pointer ahead of read pointer");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (!pend_valid_reg && !preempt_reg))
        else $error("event left pending after final result");
`endif

endmodule

/* tb/sv/sleep_wake_time_slice_scheduler_tb.sv */
// Self-checking testbench for the sleep/wake time-slice scheduler.
`timescale 1ns / 100ps

module sleep_wake_time_slice_scheduler_tb;
    import swts_pkg::*;

    localparam int NUM_PROCS = 16;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  pid;
        logic             running;
        logic [CLK_W-1:0] dur;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } sched_event_t;

    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_val;
        request_t    rq;
        bit          ack_only;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [RUN_W-1:0]       cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // proc_id[3:0], has_running[4], sleep_ticks[36:5]
    logic [REQ_W-1:0]       s_axis_tuser;   // req_type[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // event_id[3:0]
    logic [KIND_W-1:0]      m_axis_tuser;   // event_kind[1:0]
    logic                   m_axis_tlast;   // last

    // scheduler shadow state
    logic [CLK_W-1:0] sh_clock;
    logic [ID_W-1:0]  sh_sleepers [$];
    logic [CLK_W-1:0] sh_wake [NUM_PROCS];
    logic [RUN_W-1:0] sh_run [NUM_PROCS];
    logic [RUN_W-1:0] sh_slice;

    sched_event_t pending_events [$];
    dir_row_t     dir_tab [$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;
    bit           hold_sink = 1'b0;

    sleep_wake_time_slice_scheduler #(
        .NUM_PROCS(NUM_PROCS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("sleep_wake_time_slice_scheduler_tb NOT OK");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Events one request produces; updates the shadow state.
    function automatic void predict_events(input request_t rq, output sched_event_t evs [$]);
        logic [ID_W-1:0] kept [$];
        evs.delete();
        case (rq.req)
            REQ_TICK:
            begin
                sh_clock = sh_clock + 1;
                foreach (sh_sleepers[i])
                begin
                    if (sh_wake[sh_sleepers[i]] <= sh_clock)
                        evs.push_back('{kind: EV_WOKEN, id: sh_sleepers[i], last: 1'b0});
                    else
                        kept.push_back(sh_sleepers[i]);
                end
                sh_sleepers = kept;
                // id 0 is the idle process and never accrues run time
                if (rq.running && rq.pid != 0 && rq.pid < NUM_PROCS)
                begin
                    sh_run[rq.pid] = sh_run[rq.pid] + 1;
                    if (sh_run[rq.pid] == sh_slice)
                        evs.push_back('{kind: EV_PREEMPT, id: rq.pid, last: 1'b0});
                end
            end
            REQ_SLEEP:
            begin
                if (rq.running && rq.pid < NUM_PROCS && sh_sleepers.size() < NUM_PROCS)
                begin
                    sh_wake[rq.pid] = sh_clock + rq.dur;
                    sh_sleepers.push_back(rq.pid);
                end
            end
            REQ_DISPATCH:
            begin
                if (rq.pid < NUM_PROCS)
                    sh_run[rq.pid] = '0;
            end
            default:
            begin
            end
        endcase
        if (evs.size() == 0)
            evs.push_back('{kind: EV_ACK, id: '0, last: 1'b0});
        evs[evs.size() - 1].last = 1'b1;
    endfunction

    function automatic request_t rand_request(input bit storm);
        request_t rq;
        int       sel;
        int       k;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        rq.dur = $urandom();
        rq.pid = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
        rq.running = ($urandom_range(0, 9) != 0);
        if (sel < (storm ? 25 : 50))
            rq.req = REQ_TICK;
        else if (sel < (storm ? 90 : 78))
        begin
            rq.req = REQ_SLEEP;
            // mostly short naps; near-max durations wrap and come due at once
            if (storm && k < 8)
                rq.dur = $urandom_range(15, 50);
            else if (k < 6)
                rq.dur = $urandom_range(0, 6);
            else if (k < 8)
                rq.dur = $urandom_range(7, 25);
            else if (k == 8)
                rq.dur = 32'hFFFF_FFFF - $urandom_range(0, 4);
            else if ($urandom_range(0, 2) != 0)
                rq.dur = $urandom_range(30, 90);
        end
        else if (sel < 96)
            rq.req = REQ_DISPATCH;
        else
            rq.req = REQ_UNKNOWN;
        return rq;
    endfunction

    task automatic send_request(input request_t rq, input bit ack_only);
        sched_event_t evs [$];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.req;
        s_axis_tdata  <= IN_TDATA_W'({rq.dur, rq.running, rq.pid});
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_events(rq, evs);
        if (ack_only)
            pending_events.push_back('{kind: EV_ACK, id: '0, last: 1'b1});
        else
            foreach (evs[i])
                pending_events.push_back(evs[i]);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Register writes only once every outstanding event has drained.
    task automatic write_slice(input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        sh_slice = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_row(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] pid,
                                    input logic running, input logic [CLK_W-1:0] dur,
                                    input bit ack_only);
        dir_row_t row;
        row.is_cfg   = 1'b0;
        row.cfg_val  = '0;
        row.rq       = '{req: req, pid: pid, running: running, dur: dur};
        row.ack_only = ack_only;
        dir_tab.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [15:0] val);
        dir_row_t row;
        row.is_cfg   = 1'b1;
        row.cfg_val  = val;
        row.rq       = '0;
        row.ack_only = 1'b0;
        dir_tab.push_back(row);
    endfunction

    initial
    begin : sink_driver
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                // long back-pressure: scheduler must fill up and stall its input
                hold_sink = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : event_monitor
        sched_event_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
                flag_mismatch($sformatf("unexpected event kind %0d id %0d last %0d",
                                        m_axis_tuser, m_axis_tdata[3:0], m_axis_tlast));
            else
            begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.kind)
                    flag_mismatch($sformatf("event_kind %0d, wanted %0d",
                                            m_axis_tuser, want.kind));
                if (m_axis_tdata[3:0] !== want.id)
                    flag_mismatch($sformatf("event_id %0d, wanted %0d",
                                            m_axis_tdata[3:0], want.id));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("last %0d, wanted %0d", m_axis_tlast, want.last));
            end
        end
    end

    initial
    begin : stimulus
        request_t rq;
        int       n;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_TICK;

        sh_clock = '0;
        sh_sleepers.delete();
        sh_slice = SLICE_LEN_RST;
        foreach (sh_run[i])
        begin
            sh_run[i]  = '0;
            sh_wake[i] = '0;
        end

        add_row(REQ_TICK,     4'd0,  1'b0, 32'd0,         1'b1);  // quiet tick after reset
        add_row(REQ_DISPATCH, 4'd15, 1'b1, 32'd0,         1'b1);
        add_row(REQ_UNKNOWN,  4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1);
        add_row(REQ_SLEEP,    4'd5,  1'b0, 32'd0,         1'b1);  // nobody running: dropped
        add_row(REQ_SLEEP,    4'd0,  1'b1, 32'd0,         1'b1);  // idle process sleeps
        add_row(REQ_SLEEP,    4'd15, 1'b1, 32'd2,         1'b1);
        add_row(REQ_SLEEP,    4'd7,  1'b1, 32'hFFFF_FFFF, 1'b1);  // wake time wraps
        add_row(REQ_TICK,     4'd3,  1'b1, 32'd0,         1'b0);
        add_cfg(16'd1);
        add_row(REQ_DISPATCH, 4'd3,  1'b1, 32'd0,         1'b1);
        add_row(REQ_TICK,     4'd3,  1'b1, 32'd0,         1'b0);  // woken then preempted
        add_row(REQ_TICK,     4'd3,  1'b1, 32'd0,         1'b0);  // count past slice
        add_row(REQ_TICK,     4'd0,  1'b1, 32'd0,         1'b1);
        add_cfg(16'hFFFF);
        add_row(REQ_SLEEP,    4'd9,  1'b1, 32'd100,       1'b1);
        add_row(REQ_SLEEP,    4'd9,  1'b1, 32'd1,         1'b1);  // same id again
        add_row(REQ_TICK,     4'd2,  1'b1, 32'd0,         1'b0);
        add_row(REQ_TICK,     4'd15, 1'b0, 32'hFFFF_FFFF, 1'b1);
        add_row(REQ_TICK,     4'd15, 1'b1, 32'd0,         1'b0);
        add_row(REQ_SLEEP,    4'd15, 1'b1, 32'd0,         1'b1);
        add_row(REQ_TICK,     4'd15, 1'b1, 32'd0,         1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_slice(dir_tab[i].cfg_val);
            else
                send_request(dir_tab[i].rq, dir_tab[i].ack_only);
        end

        // phase 2 is sleep-heavy so the sleep queue fills and overflows
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       write_slice(16'd1);
                1:       write_slice(16'($urandom_range(2, 5)));
                2:       write_slice(16'($urandom_range(3, 8)));
                3:       write_slice(16'hFFFF);
                default: write_slice(16'($urandom_range(1, 6)));
            endcase
            idle_on = (phase != 4);
            for (n = 0; n < 70; n++)
            begin
                if (phase == 1 && n == 20)
                    hold_sink = 1'b1;
                rq = rand_request(phase == 2);
                send_request(rq, 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("sleep_wake_time_slice_scheduler_tb OK");
        else
            $display("sleep_wake_time_slice_scheduler_tb NOT OK");
        $finish;
    end

endmodule
